FILE: hw/rtl/inductive_line_sensor_error_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the inductive line sensor error block
// Each macro takes a label, clock, reset, antecedent, consequent and message.
// ----------------------------------------------------------------------------
`ifndef INDUCTIVE_LINE_SENSOR_ERROR_ASSERT_SVH
`define INDUCTIVE_LINE_SENSOR_ERROR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ILSE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ILSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ILSE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define ILSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/ilse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilse_pkg
// Shared constants and types of the inductive line sensor error block.
// ----------------------------------------------------------------------------
package ilse_pkg;

   // Default widths.
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF   = 12;

   // Result format: signed Q4.12 in 16 bits.
   localparam int QBITS = 16;
   localparam logic signed [QBITS-1:0] Q_MAX = 16'sh7FFF;
   localparam logic signed [QBITS-1:0] Q_MIN = 16'sh8000;

   // Protection hold counter.
   localparam int HOLD_W = 10;
   localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 10'd500;
   localparam int THRESHOLD_RST = 40;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS = 2'd3;

   // Status from the shared divider back to the sequencer.
   typedef struct packed {
      logic done;
      logic zero_den;
   } div_sts_type;

endpackage

FILE: hw/rtl/ilse_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilse_div
// Shared restoring divider: (num * 2^FRAC_BITS) / den, truncated toward zero
// and saturated to signed Q4.12. One quotient bit per cycle, 16 steps.
// ----------------------------------------------------------------------------
`include "inductive_line_sensor_error_assert.svh"

module ilse_div #(
   parameter int SAMPLE_BITS = ilse_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = ilse_pkg::FRAC_BITS_DEF,
   localparam int OP_W = ((SAMPLE_BITS > ilse_pkg::QBITS) ? SAMPLE_BITS
                          : ilse_pkg::QBITS) + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [OP_W-1:0]     num,
   input  logic signed [OP_W-1:0]     den,
   output ilse_pkg::div_sts_type      sts,
   output logic signed [ilse_pkg::QBITS-1:0] quot
);

   localparam int QB     = ilse_pkg::QBITS;
   localparam int SHIFT  = (FRAC_BITS > QB - 1) ? FRAC_BITS : QB - 1;
   localparam int ACC_W  = OP_W + SHIFT;
   localparam int CNT_W  = $clog2(QB);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QB - 1);

   logic [ACC_W-1:0] rem_ff;
   logic [ACC_W-1:0] dsh_ff;
   logic [QB-1:0]    q_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic             neg_ff;
   logic             zero_ff;
   logic signed [QB-1:0] quot_ff;

   logic [OP_W-1:0]  num_mag;
   logic [OP_W-1:0]  den_mag;
   logic             ge;
   logic [QB-1:0]    q_in;
   logic signed [QB-1:0] quot_in;

   // Operand magnitudes.
   assign num_mag = num[OP_W-1] ? OP_W'(-num) : OP_W'(num);
   assign den_mag = den[OP_W-1] ? OP_W'(-den) : OP_W'(den);

   // One restoring step: compare, conditionally subtract, shift in a bit.
   assign ge   = (rem_ff >= dsh_ff);
   assign q_in = {q_ff[QB-2:0], ge};

   // Final sign and saturation; the top quotient bit flags an overflow.
   always_comb begin
      if (zero_ff) begin
         quot_in = '0;
      end else if (q_in[QB-1]) begin
         quot_in = neg_ff ? ilse_pkg::Q_MIN : ilse_pkg::Q_MAX;
      end else if (neg_ff) begin
         quot_in = -$signed(q_in);
      end else begin
         quot_in = $signed(q_in);
      end
   end

   // Divider sequencing.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= ACC_W'(num_mag) << FRAC_BITS;
            dsh_ff  <= ACC_W'(den_mag) << (QB - 1);
            q_ff    <= '0;
            cnt_ff  <= '0;
            neg_ff  <= num[OP_W-1] ^ den[OP_W-1];
            zero_ff <= (den == '0);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? (rem_ff - dsh_ff) : rem_ff;
            dsh_ff <= dsh_ff >> 1;
            q_ff   <= q_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               quot_ff <= quot_in;
            end
         end
      end
   end

   assign sts.done     = done_ff;
   assign sts.zero_den = zero_ff;
   assign quot         = quot_ff;

   // A new division is only launched on an idle unit.
   `ILSE_ASSERT_NOW(a_start_idle, clock, reset, start, !busy_ff, "divider started while busy")
   // A launch always begins a fresh step count.
   `ILSE_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && cnt_ff == '0, "divider launch lost")
   // Completion coincides with the unit going idle.
   `ILSE_ASSERT_NOW(a_done_idle, clock, reset, done_ff, !busy_ff && $past(busy_ff), "done without work")

endmodule

FILE: hw/rtl/inductive_line_sensor_error.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inductive_line_sensor_error
// Clamps three inductor samples, tracks per-channel min/max in calibrate
// mode, normalizes each channel and, in run mode, forms the steering error
// with a shared divider, and runs a loss-of-signal protection latch.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req_*     in         req_valid/req_stall  func, three samples, stop line
//  rsp_*     out        rsp_valid/rsp_stall  three norms, error, status bits
//  csr_*     in         csr_valid/csr_ready  csr_index, csr_data
//
// A run request computes four quotients and a calibrate request three, one
// after another on the shared divider: each is a launch, 16 divider steps
// and a hand-back. No new request is accepted until the result is issued.
// Reset is synchronous and active high; it restores the min/max trackers and
// the protection latch. A stalled response is held in the output register;
// the block waits for it only when the next result is ready. csr_ready is
// always high.
// ----------------------------------------------------------------------------
`include "inductive_line_sensor_error_assert.svh"

module inductive_line_sensor_error #(
   parameter int SAMPLE_BITS = ilse_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = ilse_pkg::FRAC_BITS_DEF,
   localparam int CSR_W = (SAMPLE_BITS > ilse_pkg::HOLD_W) ? SAMPLE_BITS
                          : ilse_pkg::HOLD_W
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [SAMPLE_BITS-1:0]             req_left_sample,
   input  logic [SAMPLE_BITS-1:0]             req_right_sample,
   input  logic [SAMPLE_BITS-1:0]             req_mid_sample,
   input  logic                               req_stop_line_seen,
   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [ilse_pkg::QBITS-1:0]  rsp_left_norm_q,
   output logic signed [ilse_pkg::QBITS-1:0]  rsp_right_norm_q,
   output logic signed [ilse_pkg::QBITS-1:0]  rsp_mid_norm_q,
   output logic signed [ilse_pkg::QBITS-1:0]  rsp_steer_error_q,
   output logic                               rsp_error_valid,
   output logic                               rsp_protect_tripped,
   output logic                               rsp_protect_active,
   // Configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ilse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]                   csr_data
);

   localparam int QB    = ilse_pkg::QBITS;
   localparam int HW    = ilse_pkg::HOLD_W;
   localparam int OP_W  = ((SAMPLE_BITS > QB) ? SAMPLE_BITS : QB) + 1;
   localparam int ERR_W = QB + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CH_LEFT,
      CH_RIGHT,
      CH_MID,
      CH_ERR
   } chan_type;

   state_type state_ff;
   chan_type  sel_ff;
   logic      start_ff;

   // Configuration registers.
   logic [SAMPLE_BITS-1:0] clamp_low_ff;
   logic [SAMPLE_BITS-1:0] clamp_high_ff;
   logic [SAMPLE_BITS-1:0] threshold_ff;
   logic [HW-1:0]          hold_ticks_ff;

   // Calibration trackers and protection state.
   logic [SAMPLE_BITS-1:0] left_max_ff,  left_min_ff;
   logic [SAMPLE_BITS-1:0] right_max_ff, right_min_ff;
   logic [SAMPLE_BITS-1:0] mid_max_ff,   mid_min_ff;
   logic                   latch_ff;
   logic [HW-1:0]          hold_cnt_ff;

   // Current request.
   logic [SAMPLE_BITS-1:0] l_ff, r_ff, m_ff;
   logic                   run_ff;
   logic                   stop_ff;
   logic signed [QB-1:0]   ln_ff, rn_ff, mn_ff, err_ff;
   logic                   bad_ff;

   // Response register.
   logic                   rsp_valid_ff;
   logic signed [QB-1:0]   rsp_ln_ff, rsp_rn_ff, rsp_mn_ff, rsp_err_ff;
   logic                   rsp_ok_ff, rsp_trip_ff, rsp_active_ff;

   logic                   accept;
   logic                   finish_go;
   logic [SAMPLE_BITS-1:0] l_in, r_in, m_in;
   logic signed [OP_W-1:0] op_num, op_den;
   logic signed [ERR_W-1:0] err_num, err_den;
   logic                   trip;
   logic                   latch_set;
   logic [HW-1:0]          cnt_inc;
   logic                   release_hold;
   ilse_pkg::div_sts_type  div_sts;
   logic signed [QB-1:0]   div_quot;

   // Clamp a raw sample: upper limit first, then lower limit.
   function automatic logic [SAMPLE_BITS-1:0] limit_sample(
      input logic [SAMPLE_BITS-1:0] raw,
      input logic [SAMPLE_BITS-1:0] lo,
      input logic [SAMPLE_BITS-1:0] hi
   );
      logic [SAMPLE_BITS-1:0] x;
      x = (raw > hi) ? hi : raw;
      x = (x < lo) ? lo : x;
      return x;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign l_in = limit_sample(req_left_sample,  clamp_low_ff, clamp_high_ff);
   assign r_in = limit_sample(req_right_sample, clamp_low_ff, clamp_high_ff);
   assign m_in = limit_sample(req_mid_sample,   clamp_low_ff, clamp_high_ff);

   // Operands for the shared divider.
   assign err_num = ERR_W'(ln_ff) - ERR_W'(rn_ff);
   assign err_den = ERR_W'(ln_ff) + ERR_W'(rn_ff);

   always_comb begin
      unique case (sel_ff)
         CH_LEFT: begin
            op_num = $signed(OP_W'(l_ff) - OP_W'(left_min_ff));
            op_den = $signed(OP_W'(left_max_ff) - OP_W'(left_min_ff));
         end
         CH_RIGHT: begin
            op_num = $signed(OP_W'(r_ff) - OP_W'(right_min_ff));
            op_den = $signed(OP_W'(right_max_ff) - OP_W'(right_min_ff));
         end
         CH_MID: begin
            op_num = $signed(OP_W'(m_ff) - OP_W'(mid_min_ff));
            op_den = $signed(OP_W'(mid_max_ff) - OP_W'(mid_min_ff));
         end
         CH_ERR: begin
            op_num = OP_W'(err_num);
            op_den = OP_W'(err_den);
         end
      endcase
   end

   ilse_div #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .num   (op_num),
      .den   (op_den),
      .sts   (div_sts),
      .quot  (div_quot)
   );

   // Loss-of-signal guard and hold counter.
   assign trip = run_ff && (l_ff < threshold_ff) && (r_ff < threshold_ff) &&
                 (m_ff < threshold_ff) && !stop_ff;
   assign latch_set    = latch_ff || trip;
   assign cnt_inc      = latch_set ? (hold_cnt_ff + 1'b1) : hold_cnt_ff;
   assign release_hold = (cnt_inc >= hold_ticks_ff);

   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer, trackers, configuration and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sel_ff        <= CH_LEFT;
         start_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         clamp_low_ff  <= '0;
         clamp_high_ff <= '1;
         threshold_ff  <= SAMPLE_BITS'(ilse_pkg::THRESHOLD_RST);
         hold_ticks_ff <= ilse_pkg::HOLD_TICKS_RST;
         left_max_ff   <= '0;
         right_max_ff  <= '0;
         mid_max_ff    <= '0;
         left_min_ff   <= '1;
         right_min_ff  <= '1;
         mid_min_ff    <= '1;
         latch_ff      <= 1'b0;
         hold_cnt_ff   <= '0;
      end else begin
         start_ff <= 1'b0;

         // Configuration writes.
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ilse_pkg::CSR_CLAMP_LOW:  clamp_low_ff  <= csr_data[SAMPLE_BITS-1:0];
               ilse_pkg::CSR_CLAMP_HIGH: clamp_high_ff <= csr_data[SAMPLE_BITS-1:0];
               ilse_pkg::CSR_THRESHOLD:  threshold_ff  <= csr_data[SAMPLE_BITS-1:0];
               ilse_pkg::CSR_HOLD_TICKS: hold_ticks_ff <= csr_data[HW-1:0];
            endcase
         end

         // Response drains when taken.
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  l_ff     <= l_in;
                  r_ff     <= r_in;
                  m_ff     <= m_in;
                  run_ff   <= req_func;
                  stop_ff  <= req_stop_line_seen;
                  bad_ff   <= 1'b0;
                  sel_ff   <= CH_LEFT;
                  start_ff <= 1'b1;
                  state_ff <= ST_DIV;
                  // Calibrate mode widens the window before normalizing.
                  if (!req_func) begin
                     if (l_in > left_max_ff)  left_max_ff  <= l_in;
                     if (l_in < left_min_ff)  left_min_ff  <= l_in;
                     if (r_in > right_max_ff) right_max_ff <= r_in;
                     if (r_in < right_min_ff) right_min_ff <= r_in;
                     if (m_in > mid_max_ff)   mid_max_ff   <= m_in;
                     if (m_in < mid_min_ff)   mid_min_ff   <= m_in;
                  end
               end
            end
            ST_DIV: begin
               if (div_sts.done) begin
                  bad_ff <= bad_ff || div_sts.zero_den;
                  unique case (sel_ff)
                     CH_LEFT: begin
                        ln_ff    <= div_quot;
                        sel_ff   <= CH_RIGHT;
                        start_ff <= 1'b1;
                     end
                     CH_RIGHT: begin
                        rn_ff    <= div_quot;
                        sel_ff   <= CH_MID;
                        start_ff <= 1'b1;
                     end
                     CH_MID: begin
                        mn_ff <= div_quot;
                        if (run_ff) begin
                           sel_ff   <= CH_ERR;
                           start_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_FINISH;
                        end
                     end
                     CH_ERR: begin
                        err_ff   <= div_quot;
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end
            ST_FINISH: begin
               if (finish_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ln_ff    <= ln_ff;
                  rsp_rn_ff    <= rn_ff;
                  rsp_mn_ff    <= mn_ff;
                  rsp_err_ff   <= run_ff ? err_ff : '0;
                  rsp_ok_ff    <= run_ff && !bad_ff;
                  rsp_trip_ff  <= trip;
                  state_ff     <= ST_IDLE;
                  if (run_ff) begin
                     rsp_active_ff <= latch_set;
                     latch_ff      <= release_hold ? 1'b0 : latch_set;
                     hold_cnt_ff   <= release_hold ? '0 : cnt_inc;
                  end else begin
                     rsp_active_ff <= latch_ff;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_norm_q     = rsp_ln_ff;
   assign rsp_right_norm_q    = rsp_rn_ff;
   assign rsp_mid_norm_q      = rsp_mn_ff;
   assign rsp_steer_error_q   = rsp_err_ff;
   assign rsp_error_valid     = rsp_ok_ff;
   assign rsp_protect_tripped = rsp_trip_ff;
   assign rsp_protect_active  = rsp_active_ff;

   // One request at a time: acceptance closes the input until the result.
   `ILSE_ASSERT_NEXT(a_accept_busy, clock, reset, accept, req_stall, "request accepted while busy")
   // The hold counter only runs while the latch is set.
   `ILSE_ASSERT_NOW(a_cnt_idle, clock, reset, !latch_ff, hold_cnt_ff == '0, "hold count without latch")
   // A trip always reports the drive as disabled.
   `ILSE_ASSERT_NOW(a_trip_active, clock, reset, rsp_valid_ff && rsp_trip_ff, rsp_active_ff, "trip without active")

endmodule

FILE: tb/sv/tb_inductive_line_sensor_error.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inductive_line_sensor_error
// Self-checking bench for the inductive line sensor error block. Directed
// requests cover uncalibrated channels, flat calibration, the clamp window and
// the protection latch. Random requests under changing register settings
// follow. A bit-accurate predictor computes each response, and a checker
// compares every accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_inductive_line_sensor_error;

   localparam int SAMPLE_W = ilse_pkg::SAMPLE_BITS_DEF;
   localparam int QW = ilse_pkg::QBITS;
   localparam int HOLD_W = ilse_pkg::HOLD_W;
   localparam int CSR_DATA_W = (SAMPLE_W > HOLD_W) ? SAMPLE_W : HOLD_W;
   localparam longint Q_ONE = longint'(1) << ilse_pkg::FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_LIMIT = 10;
   localparam int MAX_IDLE = 5;
   localparam int SETTLE_CYCLES = 8;
   localparam int FINAL_WAIT = 80;

   typedef enum logic {
      FUNC_CALIBRATE = 1'b0,
      FUNC_RUN       = 1'b1
   } sensor_func_type;

   typedef struct packed {
      sensor_func_type     func;
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic [SAMPLE_W-1:0] mid;
      logic                stop_line;
   } sensor_request_type;

   typedef struct packed {
      logic signed [QW-1:0] left_q;
      logic signed [QW-1:0] right_q;
      logic signed [QW-1:0] mid_q;
      logic signed [QW-1:0] steer_error;
      logic                 error_valid;
      logic                 tripped;
      logic                 active;
   } sensor_result_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_func;
   logic [SAMPLE_W-1:0] req_left_sample;
   logic [SAMPLE_W-1:0] req_right_sample;
   logic [SAMPLE_W-1:0] req_mid_sample;
   logic req_stop_line_seen;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [QW-1:0] rsp_left_norm_q;
   logic signed [QW-1:0] rsp_right_norm_q;
   logic signed [QW-1:0] rsp_mid_norm_q;
   logic signed [QW-1:0] rsp_steer_error_q;
   logic rsp_error_valid;
   logic rsp_protect_tripped;
   logic rsp_protect_active;
   logic csr_valid;
   logic csr_ready;
   logic [ilse_pkg::CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Predictor copy of the registers and of the block state.
   logic [SAMPLE_W-1:0] cfg_clamp_low;
   logic [SAMPLE_W-1:0] cfg_clamp_high;
   logic [SAMPLE_W-1:0] cfg_threshold;
   logic [HOLD_W-1:0]   cfg_hold;
   logic [SAMPLE_W-1:0] left_lo, left_hi, right_lo, right_hi, mid_lo, mid_hi;
   logic                latch_set;
   logic [HOLD_W-1:0]   hold_count;

   sensor_result_type expected_results[$];
   bit idle_on;
   int stall_left;
   int fail_count;
   int cycle_count;
   int run_count;
   int calibrate_count;
   int trip_count;
   int write_count;

   inductive_line_sensor_error DUT (.*);

   // Clock generation.
   always #2 clock = ~clock;

   // Safety net against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, expected_results.size());
         $display("inductive_line_sensor_error: mismatch");
         $finish;
      end
   end

   // Response back-pressure: each response is held off for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         rsp_stall <= (stall_left != 0);
      end else if (rsp_valid && stall_left != 0) begin
         stall_left--;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end
   end

   // Response checker: compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      sensor_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("[%0t] response with no request outstanding", $time);
         end else begin
            want = expected_results.pop_front();
            if (rsp_left_norm_q !== want.left_q || rsp_right_norm_q !== want.right_q
                || rsp_mid_norm_q !== want.mid_q
                || rsp_steer_error_q !== want.steer_error
                || rsp_error_valid !== want.error_valid
                || rsp_protect_tripped !== want.tripped
                || rsp_protect_active !== want.active) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("[%0t] wrong response: expected l=%0d r=%0d m=%0d err=%0d ok=%0b",
                           $time, $signed(want.left_q), $signed(want.right_q),
                           $signed(want.mid_q), $signed(want.steer_error),
                           want.error_valid);
                  $display("       trip=%0b act=%0b | got l=%0d r=%0d m=%0d err=%0d ok=%0b",
                           want.tripped, want.active, rsp_left_norm_q, rsp_right_norm_q,
                           rsp_mid_norm_q, rsp_steer_error_q, rsp_error_valid);
                  $display("       got trip=%0b act=%0b", rsp_protect_tripped,
                           rsp_protect_active);
               end
            end
         end
      end
   end

   // Limit a raw sample to the clamp window, upper limit first.
   function automatic logic [SAMPLE_W-1:0] clamp_sample(logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_W-1:0] x;
      x = raw;
      if (x > cfg_clamp_high) x = cfg_clamp_high;
      if (x < cfg_clamp_low) x = cfg_clamp_low;
      return x;
   endfunction

   // Q4.12 quotient truncated toward zero and saturated; a zero divisor gives zero.
   function automatic longint scaled_ratio(longint num, longint den);
      longint q;
      if (den == 0) return 0;
      q = (num * Q_ONE) / den;
      if (q > longint'(ilse_pkg::Q_MAX)) q = ilse_pkg::Q_MAX;
      if (q < longint'(ilse_pkg::Q_MIN)) q = ilse_pkg::Q_MIN;
      return q;
   endfunction

   // Work out the response to one accepted request and advance the state.
   function automatic sensor_result_type predict_sensor_result(sensor_request_type rq);
      sensor_result_type res;
      logic [SAMPLE_W-1:0] l, r, m;
      longint ln, rn, mn, left_den, right_den, mid_den, norm_sum;
      bit run;
      run = (rq.func == FUNC_RUN);
      l = clamp_sample(rq.left);
      r = clamp_sample(rq.right);
      m = clamp_sample(rq.mid);

      // Calibration widens the trackers before normalizing.
      if (!run) begin
         if (l > left_hi) left_hi = l;
         if (l < left_lo) left_lo = l;
         if (r > right_hi) right_hi = r;
         if (r < right_lo) right_lo = r;
         if (m > mid_hi) mid_hi = m;
         if (m < mid_lo) mid_lo = m;
      end

      left_den = longint'(left_hi) - longint'(left_lo);
      right_den = longint'(right_hi) - longint'(right_lo);
      mid_den = longint'(mid_hi) - longint'(mid_lo);
      ln = scaled_ratio(longint'(l) - longint'(left_lo), left_den);
      rn = scaled_ratio(longint'(r) - longint'(right_lo), right_den);
      mn = scaled_ratio(longint'(m) - longint'(mid_lo), mid_den);

      res.steer_error = '0;
      res.tripped = 1'b0;
      res.error_valid = run && left_den != 0 && right_den != 0 && mid_den != 0;
      if (run) begin
         norm_sum = ln + rn;
         res.steer_error = QW'(scaled_ratio(ln - rn, norm_sum));
         if (norm_sum == 0) res.error_valid = 1'b0;
         // Loss of signal on all three channels trips the latch unless a stop line is seen.
         if (l < cfg_threshold && r < cfg_threshold && m < cfg_threshold && !rq.stop_line)
         begin
            latch_set = 1'b1;
            res.tripped = 1'b1;
         end
         res.active = latch_set;
         if (latch_set) hold_count = hold_count + 1'b1;
         if (hold_count >= cfg_hold) begin
            hold_count = '0;
            latch_set = 1'b0;
         end
      end else begin
         res.active = latch_set;
      end

      res.left_q = ln[QW-1:0];
      res.right_q = rn[QW-1:0];
      res.mid_q = mn[QW-1:0];
      return res;
   endfunction

   function automatic sensor_request_type make_request(sensor_func_type func, int l, int r,
                                                       int m, bit stop_line);
      sensor_request_type rq;
      rq.func = func;
      rq.left = l[SAMPLE_W-1:0];
      rq.right = r[SAMPLE_W-1:0];
      rq.mid = m[SAMPLE_W-1:0];
      rq.stop_line = stop_line;
      return rq;
   endfunction

   // Send one request after a drawn gap; valid stays high after acceptance.
   task automatic send_request(input sensor_request_type rq);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= rq.func;
      req_left_sample <= rq.left;
      req_right_sample <= rq.right;
      req_mid_sample <= rq.mid;
      req_stop_line_seen <= rq.stop_line;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(predict_sensor_result(rq));
      if (rq.func == FUNC_RUN) run_count++;
      else calibrate_count++;
      if (expected_results[$].tripped) trip_count++;
   endtask

   // Drop valid and wait until every predicted response has been checked.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register and mirror it in the predictor.
   task automatic write_register(input logic [ilse_pkg::CSR_IDX_W-1:0] index,
                                 input int value);
      csr_index <= index;
      csr_data <= CSR_DATA_W'(value);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         ilse_pkg::CSR_CLAMP_LOW: cfg_clamp_low = value[SAMPLE_W-1:0];
         ilse_pkg::CSR_CLAMP_HIGH: cfg_clamp_high = value[SAMPLE_W-1:0];
         ilse_pkg::CSR_THRESHOLD: cfg_threshold = value[SAMPLE_W-1:0];
         ilse_pkg::CSR_HOLD_TICKS: cfg_hold = value[HOLD_W-1:0];
         default: ;
      endcase
      write_count++;
      @(posedge clock);
   endtask

   // Run requests at reset settings, before any calibration: every channel divisor is negative.
   task automatic test_uncalibrated();
      send_request(make_request(FUNC_RUN, 0, 0, 0, 1'b0));
      send_request(make_request(FUNC_RUN, 4095, 4095, 4095, 1'b1));
      send_request(make_request(FUNC_RUN, 'hAAA, 'h555, 'hFFF, 1'b0));
      send_request(make_request(FUNC_RUN, 'h555, 'hAAA, 0, 1'b1));
      send_request(make_request(FUNC_RUN, 39, 39, 39, 1'b1));
   endtask

   // Flat and narrow calibration: zero divisors, then zero sum and a plain error.
   task automatic test_degenerate_calibration();
      send_request(make_request(FUNC_CALIBRATE, 2000, 2000, 2000, 1'b0));
      send_request(make_request(FUNC_RUN, 2000, 1000, 3000, 1'b0));
      send_request(make_request(FUNC_CALIBRATE, 1800, 2000, 2000, 1'b1));
      send_request(make_request(FUNC_RUN, 1900, 0, 0, 1'b1));
      send_request(make_request(FUNC_CALIBRATE, 1800, 2100, 2010, 1'b0));
      send_request(make_request(FUNC_RUN, 1900, 2100, 4095, 1'b1));
      send_request(make_request(FUNC_RUN, 1800, 2000, 2010, 1'b1));
   endtask

   // Clamp window: narrow, crossed, pinned at zero, then back to full range.
   task automatic test_clamp_window();
      wait_for_results();
      write_register(ilse_pkg::CSR_CLAMP_LOW, 2040);
      write_register(ilse_pkg::CSR_CLAMP_HIGH, 2060);
      send_request(make_request(FUNC_RUN, 0, 4095, 2050, 1'b0));
      send_request(make_request(FUNC_CALIBRATE, 0, 4095, 4095, 1'b0));
      wait_for_results();
      write_register(ilse_pkg::CSR_CLAMP_LOW, 4095);
      write_register(ilse_pkg::CSR_CLAMP_HIGH, 0);
      send_request(make_request(FUNC_RUN, 0, 123, 4095, 1'b0));
      wait_for_results();
      write_register(ilse_pkg::CSR_CLAMP_LOW, 0);
      send_request(make_request(FUNC_RUN, 4095, 2000, 17, 1'b0));
      wait_for_results();
      write_register(ilse_pkg::CSR_CLAMP_HIGH, 4095);
   endtask

   // Protection latch: threshold extremes, short holds and a trip while latched.
   task automatic test_protection_hold();
      wait_for_results();
      write_register(ilse_pkg::CSR_THRESHOLD, 4095);
      write_register(ilse_pkg::CSR_HOLD_TICKS, 1);
      send_request(make_request(FUNC_RUN, 100, 100, 100, 1'b0));
      send_request(make_request(FUNC_RUN, 4095, 0, 0, 1'b0));
      send_request(make_request(FUNC_CALIBRATE, 2050, 2050, 2050, 1'b0));
      wait_for_results();
      write_register(ilse_pkg::CSR_THRESHOLD, 0);
      send_request(make_request(FUNC_RUN, 0, 0, 0, 1'b0));
      wait_for_results();
      write_register(ilse_pkg::CSR_THRESHOLD, 50);
      write_register(ilse_pkg::CSR_HOLD_TICKS, 3);
      send_request(make_request(FUNC_RUN, 0, 1, 2, 1'b0));
      send_request(make_request(FUNC_RUN, 4095, 0, 0, 1'b0));
      send_request(make_request(FUNC_CALIBRATE, 2050, 2050, 2050, 1'b1));
      send_request(make_request(FUNC_RUN, 49, 49, 49, 1'b0));
      send_request(make_request(FUNC_RUN, 50, 0, 0, 1'b0));
      wait_for_results();
      write_register(ilse_pkg::CSR_HOLD_TICKS, 1023);
      send_request(make_request(FUNC_RUN, 0, 0, 0, 1'b0));
   endtask

   // Random phases: fresh settings each phase, calibration band widening per phase.
   task automatic test_random_traffic(input int phases, input int per_phase);
      int band;
      int lo;
      int hi;
      int thr;
      int hold;
      sensor_request_type rq;
      for (int p = 0; p < phases; p++) begin
         wait_for_results();
         lo = 0;
         hi = 4095;
         case ($urandom_range(0, 5))
            0: lo = $urandom_range(0, 600);
            1: hi = $urandom_range(2000, 4095);
            2: begin
               lo = $urandom_range(2048, 4095);
               hi = $urandom_range(0, 2047);
            end
            default: ;
         endcase
         thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(20, 300);
         hold = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 24);
         write_register(ilse_pkg::CSR_CLAMP_LOW, lo);
         write_register(ilse_pkg::CSR_CLAMP_HIGH, hi);
         write_register(ilse_pkg::CSR_THRESHOLD, thr);
         write_register(ilse_pkg::CSR_HOLD_TICKS, hold);
         idle_on = ($urandom_range(0, 3) != 0);
         band = 64 << p;
         if (band > 2048) band = 2048;
         repeat (per_phase) begin
            if ($urandom_range(0, 9) == 0) begin
               rq = make_request(FUNC_CALIBRATE, $urandom_range(2048 - band, 2047 + band),
                                 $urandom_range(2048 - band, 2047 + band),
                                 $urandom_range(2048 - band, 2047 + band), 1'b0);
            end else if ($urandom_range(0, 4) == 0) begin
               // A weak-signal request that may trip the guard.
               rq = make_request(FUNC_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom_range(0, 63), 1'b0);
            end else begin
               rq = make_request(FUNC_RUN, $urandom_range(0, 4095), $urandom_range(0, 4095),
                                 $urandom_range(0, 4095), 1'b0);
            end
            rq.stop_line = ($urandom_range(0, 3) == 0);
            send_request(rq);
         end
      end
   endtask

   // Main sequence.
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = 1'b0;
      req_left_sample = '0;
      req_right_sample = '0;
      req_mid_sample = '0;
      req_stop_line_seen = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cfg_clamp_low = '0;
      cfg_clamp_high = '1;
      cfg_threshold = SAMPLE_W'(ilse_pkg::THRESHOLD_RST);
      cfg_hold = ilse_pkg::HOLD_TICKS_RST;
      left_lo = '1;
      right_lo = '1;
      mid_lo = '1;
      left_hi = '0;
      right_hi = '0;
      mid_hi = '0;
      latch_set = 1'b0;
      hold_count = '0;
      idle_on = 1'b1;
      fail_count = 0;
      run_count = 0;
      calibrate_count = 0;
      trip_count = 0;
      write_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_uncalibrated();
      test_degenerate_calibration();
      test_clamp_window();
      test_protection_hold();
      test_random_traffic(9, 210);

      wait_for_results();
      repeat (FINAL_WAIT) @(posedge clock);
      if (expected_results.size() != 0) fail_count++;
      $display("Checked %0d sensor requests (%0d run, %0d calibrate), %0d guard trips.",
               run_count + calibrate_count, run_count, calibrate_count, trip_count);
      $display("Applied %0d register writes; %0d failures found.", write_count, fail_count);
      if (fail_count == 0) begin
         $display("inductive_line_sensor_error: match");
      end else begin
         $display("inductive_line_sensor_error: mismatch");
      end
      $finish;
   end

endmodule
